[rtl/u2a_pkg.sv]
package u2a_pkg;

	// number of value bits taken into the conversion (8 to 64)
	localparam int VALUE_WIDTH = 64;
	// value bits are counted down during the shift phase
	localparam int CNT_W = $clog2(VALUE_WIDTH);

	// digit store: wide enough for the longest decimal result
	localparam int NDIG = 20;
	localparam int DIG_W = 4;
	localparam int STORE_W = NDIG * DIG_W;
	localparam int REM_W = $clog2(NDIG + 1);

	localparam logic [6:0] ASCII_ZERO = 7'd48;
	localparam logic [6:0] ASCII_A_MINUS_TEN = 7'd87;

	// converted number handed from the shifter to the character emitter
	typedef struct packed {
		logic valid;
		logic [STORE_W-1:0] digits;
	} conv_t;

	// one digit to its character, lowercase letters for ten and above
	function automatic logic [6:0] digit_ascii(input logic [DIG_W-1:0] d);
		logic [6:0] c;
		if (d < DIG_W'(10)) begin
			c = ASCII_ZERO + {3'b000, d};
		end else begin
			c = ASCII_A_MINUS_TEN + {3'b000, d};
		end
		return c;
	endfunction

endpackage

[rtl/unsigned_to_ascii_digits_core.sv]
// unsigned to ascii digits, decimal or lowercase hex
//
// slave side: one beat carries the value in s_tdata and the radix in s_tuser
// (0 decimal, 1 hex). master side: one beat per character, most significant
// digit first, leading zeros dropped, a zero value gives a single '0';
// m_tlast marks the final character of each number.
//
// a value is converted by a shift-and-add-three register (plain shift in hex
// mode), one value bit per cycle. the digit store is then handed to the
// emitter, which drops leading zeros and shifts out one digit per cycle while
// the receiver keeps up, 20 digit slots per number. the converter takes the
// next value while the emitter is still sending.
//
// reset empties both stages and drops m_tvalid. when the receiver stalls the
// character register holds, the emitter waits at its next character, and the
// converter stops once it has a finished number waiting, with s_tready low.
module unsigned_to_ascii_digits_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,  // value[63:0]
	input  logic s_tuser,         // req_type
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,   // digit_char[6:0], zero pad
	output logic m_tlast          // last_char
);
	import u2a_pkg::*;

	conv_t conv;
	logic take;

	u2a_convert u_convert (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.conv     (conv),
		.take     (take)
	);

	u2a_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.conv     (conv),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/u2a_convert.sv]
module u2a_convert (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,  // value[63:0]
	input  logic s_tuser,         // req_type (0 decimal, 1 hex)
	output u2a_pkg::conv_t conv,
	input  logic take
);
	import u2a_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		SHIFT,
		DONE
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic hex_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [STORE_W-1:0] bcd_q;
	logic [STORE_W-1:0] adj;
	logic accept;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == IDLE);
	assign conv.valid = (state_q == DONE);
	assign conv.digits = bcd_q;

	// add three to every decimal digit of five or more before the shift
	always_comb begin
		adj = bcd_q;
		if (!hex_q) begin
			for (int i = 0; i < NDIG; i++) begin
				if (bcd_q[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
					adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W] + DIG_W'(3);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= SHIFT;
						cnt_q <= CNT_W'(VALUE_WIDTH - 1);
					end
				end
				SHIFT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (take) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= s_tdata[VALUE_WIDTH-1:0];
			hex_q <= s_tuser;
			bcd_q <= '0;
		end else if (state_q == SHIFT) begin
			bcd_q <= {adj[STORE_W-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	a_no_second_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while a conversion runs");

	a_shift_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SHIFT && cnt_q == '0) |=> conv.valid)
		else $error("conversion did not finish after the last bit");

	a_hex_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(conv.valid && hex_q) |-> (bcd_q[STORE_W-1 -: STORE_W-64] == '0))
		else $error("hex digits above the value width");

	a_dec_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(conv.valid && !hex_q) |->
		(bcd_q[3:0] <= 4'd9 && bcd_q[7:4] <= 4'd9 && bcd_q[79:76] <= 4'd9))
		else $error("decimal digit out of range");

endmodule

[rtl/u2a_emit.sv]
module u2a_emit (
	input  logic clk,
	input  logic arst_n,
	input  u2a_pkg::conv_t conv,
	output logic take,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,  // digit_char[6:0], zero pad
	output logic m_tlast         // last_char
);
	import u2a_pkg::*;

	logic busy_q;
	logic started_q;
	logic [REM_W-1:0] rem_q;
	logic [STORE_W-1:0] dig_q;
	logic valid_q;
	logic [6:0] char_q;
	logic last_q;
	logic [DIG_W-1:0] top_dig;
	logic skip;
	logic emit;
	logic out_free;

	assign top_dig = dig_q[STORE_W-1 -: DIG_W];
	// leading zeros are dropped, but the final digit always goes out
	assign skip = busy_q && !started_q && (top_dig == '0) && (rem_q != REM_W'(1));
	assign out_free = !valid_q || m_tready;
	assign emit = busy_q && !skip && out_free;
	assign take = conv.valid && !busy_q;

	assign m_tvalid = valid_q;
	assign m_tdata = {1'b0, char_q};
	assign m_tlast = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			started_q <= 1'b0;
			rem_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				started_q <= 1'b0;
				rem_q <= REM_W'(NDIG);
			end else if (skip || emit) begin
				rem_q <= rem_q - REM_W'(1);
				if (emit) begin
					started_q <= 1'b1;
					if (rem_q == REM_W'(1)) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dig_q <= conv.digits;
		end else if (skip || emit) begin
			dig_q <= {dig_q[STORE_W-DIG_W-1:0], {DIG_W{1'b0}}};
		end
		if (emit) begin
			char_q <= digit_ascii(top_dig);
			last_q <= (rem_q == REM_W'(1));
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0 && rem_q <= REM_W'(NDIG)))
		else $error("digit count out of range while busy");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && rem_q == REM_W'(1)) |=> (!busy_q && m_tvalid && m_tlast))
		else $error("final digit not flagged as last");

	a_no_skip_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> !skip)
		else $error("inner zero dropped");

endmodule
